FILE: sv/cbfp_pkg.sv
// Package with shared types and frame layout constants for the camera block frame parser.
`default_nettype none

package cbfp_pkg;

  localparam int unsigned PosW = 5;

  localparam logic [7:0] SyncFirst  = 8'haf;
  localparam logic [7:0] SyncSecond = 8'hc1;

  localparam logic [PosW-1:0] PosHunt     = 5'd0;
  localparam logic [PosW-1:0] PosSync2    = 5'd1;
  localparam logic [PosW-1:0] PosType     = 5'd2;
  localparam logic [PosW-1:0] PosCsumLow  = 5'd4;
  localparam logic [PosW-1:0] PosCsumHigh = 5'd5;
  localparam logic [PosW-1:0] PosPayload  = 5'd6;
  localparam logic [PosW-1:0] PosXLow     = 5'd8;
  localparam logic [PosW-1:0] PosXHigh    = 5'd9;
  localparam logic [PosW-1:0] PosYLow     = 5'd10;
  localparam logic [PosW-1:0] PosYHigh    = 5'd11;

  localparam logic [15:0] ErrorWord = 16'h0101;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       transfer_start;
  } rx_item_t;

  typedef struct packed {
    logic        checksum_ok;
    logic [15:0] target_x;
    logic [15:0] target_y;
    logic        no_target;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/cbfp_if.sv
// Valid/ready channel interfaces for received bytes and frame results.
`default_nettype none

interface cbfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       transfer_start;

  modport source(output valid, output rx_byte, output transfer_start, input ready);
  modport sink(input valid, input rx_byte, input transfer_start, output ready);
endinterface

interface cbfp_res_if;
  logic        valid;
  logic        ready;
  logic        checksum_ok;
  logic [15:0] target_x;
  logic [15:0] target_y;
  logic        no_target;

  modport source(output valid, output checksum_ok, output target_x, output target_y,
                 output no_target, input ready);
  modport sink(input valid, input checksum_ok, input target_x, input target_y,
               input no_target, output ready);
endinterface

`default_nettype wire

FILE: sv/cbfp_core.sv
// Frame parser state and per-byte update logic.
`default_nettype none

module cbfp_core #(
  parameter int unsigned FRAME_BYTES = 20
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                step_i,
  input  cbfp_pkg::rx_item_t item_i,
  output logic               res_valid_o,
  output cbfp_pkg::result_t  res_o
);

  localparam logic [cbfp_pkg::PosW-1:0] LastPos = cbfp_pkg::PosW'(FRAME_BYTES - 1);

  logic [cbfp_pkg::PosW-1:0] pos_q, pos_d;
  logic                      done_q, done_d;
  logic [15:0]               sum_q, sum_d;
  logic [15:0]               csum_q, csum_d;
  logic [15:0]               pend_x_q, pend_x_d;
  logic [15:0]               pend_y_q, pend_y_d;
  logic [15:0]               kept_x_q, kept_x_d;
  logic [15:0]               kept_y_q, kept_y_d;

  logic [cbfp_pkg::PosW-1:0] pos;
  logic                      done;
  logic [7:0]                b;
  logic                      ok;

  always_comb begin
    b        = item_i.rx_byte;
    pos      = item_i.transfer_start ? cbfp_pkg::PosHunt : pos_q;
    done     = item_i.transfer_start ? 1'b0 : done_q;
    pos_d    = pos;
    done_d   = done;
    sum_d    = sum_q;
    csum_d   = csum_q;
    pend_x_d = pend_x_q;
    pend_y_d = pend_y_q;
    kept_x_d = kept_x_q;
    kept_y_d = kept_y_q;
    ok       = 1'b0;
    res_valid_o = 1'b0;

    if (!done) begin
      if (pos == cbfp_pkg::PosHunt) begin
        if (b == cbfp_pkg::SyncFirst) begin
          pos_d = cbfp_pkg::PosSync2;
        end
      end else if (pos == cbfp_pkg::PosSync2) begin
        if (b == cbfp_pkg::SyncSecond) begin
          pos_d = cbfp_pkg::PosType;
          sum_d = '0;
        end else if (b == cbfp_pkg::SyncFirst) begin
          pos_d = cbfp_pkg::PosSync2;
        end else begin
          pos_d = cbfp_pkg::PosHunt;
        end
      end else begin
        if (pos == cbfp_pkg::PosCsumLow) begin
          csum_d = {csum_q[15:8], b};
        end else if (pos == cbfp_pkg::PosCsumHigh) begin
          csum_d = {b, csum_q[7:0]};
        end
        if (pos >= cbfp_pkg::PosPayload) begin
          sum_d = sum_q + {8'h00, b};
          if (pos == cbfp_pkg::PosXLow) begin
            pend_x_d = {pend_x_q[15:8], b};
          end else if (pos == cbfp_pkg::PosXHigh) begin
            pend_x_d = {b, pend_x_q[7:0]};
          end else if (pos == cbfp_pkg::PosYLow) begin
            pend_y_d = {pend_y_q[15:8], b};
          end else if (pos == cbfp_pkg::PosYHigh) begin
            pend_y_d = {b, pend_y_q[7:0]};
          end
        end
        if (pos < LastPos) begin
          pos_d = pos + 1'b1;
        end else begin
          ok = (sum_d == csum_d);
          if (ok) begin
            kept_x_d = pend_x_d;
            kept_y_d = pend_y_d;
          end
          done_d      = 1'b1;
          pos_d       = cbfp_pkg::PosHunt;
          res_valid_o = 1'b1;
        end
      end
    end

    res_o.checksum_ok = ok;
    res_o.target_x    = kept_x_d;
    res_o.target_y    = kept_y_d;
    res_o.no_target   = (kept_x_d == cbfp_pkg::ErrorWord) && (kept_y_d == cbfp_pkg::ErrorWord);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= cbfp_pkg::PosHunt;
      done_q   <= 1'b0;
      sum_q    <= '0;
      csum_q   <= '0;
      pend_x_q <= '0;
      pend_y_q <= '0;
      kept_x_q <= '0;
      kept_y_q <= '0;
    end else if (step_i) begin
      pos_q    <= pos_d;
      done_q   <= done_d;
      sum_q    <= sum_d;
      csum_q   <= csum_d;
      pend_x_q <= pend_x_d;
      pend_y_q <= pend_y_d;
      kept_x_q <= kept_x_d;
      kept_y_q <= kept_y_d;
    end
  end

  // Once a frame has ended, the position counter is parked at the hunt value.
  a_done_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> pos_q == cbfp_pkg::PosHunt)
    else $error("frame done with nonzero position");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("frame position beyond frame length");

  // A transfer start restarts the hunt, so at most the first sync byte is seen.
  a_start_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.transfer_start |=> pos_q <= cbfp_pkg::PosSync2 && !done_q)
    else $error("transfer start did not restart the sync hunt");

endmodule

`default_nettype wire

FILE: sv/camera_block_frame_parser.sv
// Top level of the camera block frame parser: input register, parser, result register.
// Bytes pass the input register, then the result register. Throughput: one byte per cycle
// while the output is not stalled; the per-byte parser state update is the only loop.
// A result that waits on a stalled output holds one further byte in the input register.
// Reset (asynchronous, active low) clears all parser state to zero, hunting for sync,
// and empties both the input and the result register.
`default_nettype none

module camera_block_frame_parser #(
  parameter int unsigned FRAME_BYTES = 20
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  cbfp_rx_if.sink    rx_i,
  cbfp_res_if.source res_o
);

  logic                in_valid_q;
  cbfp_pkg::rx_item_t  in_item_q;
  logic                out_valid_q;
  cbfp_pkg::result_t   out_res_q;
  logic                step;
  logic                core_valid;
  cbfp_pkg::result_t   core_res;

  // The parse stage advances whenever it holds a byte and the result register is free or being drained.
  assign step       = in_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_item_q.rx_byte        <= rx_i.rx_byte;
      in_item_q.transfer_start <= rx_i.transfer_start;
    end
  end

  cbfp_core #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (in_item_q),
    .res_valid_o(core_valid),
    .res_o      (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= core_valid;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && core_valid) begin
      out_res_q <= core_res;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.checksum_ok = out_res_q.checksum_ok;
  assign res_o.target_x    = out_res_q.target_x;
  assign res_o.target_y    = out_res_q.target_y;
  assign res_o.no_target   = out_res_q.no_target;

  a_no_target_pattern: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_res_q.no_target |->
      out_res_q.target_x == cbfp_pkg::ErrorWord && out_res_q.target_y == cbfp_pkg::ErrorWord)
    else $error("no-target flag without error pattern");

  // A full input register behind a stalled result must not take another byte.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !res_o.ready |-> !rx_i.ready)
    else $error("input accepted while parse stage is blocked");

  a_result_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !$past(out_valid_q) |-> $past(step))
    else $error("result appeared without a parse step");

endmodule

`default_nettype wire
